[design/mrc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrc_pkg
// Types, codes and sizing constants of the motion report controller.
// ----------------------------------------------------------------------------
package mrc_pkg;

  localparam int STAGE_COUNT = 4;
  localparam int COUNT_WIDTH = 10;
  localparam int STAGE_W     = (STAGE_COUNT > 2) ? $clog2(STAGE_COUNT) : 1;
  localparam int LIMIT_W     = 10;
  localparam int CMP_W       = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'((64'd1 << COUNT_WIDTH) - 64'd1);

  // Mode codes
  localparam logic [2:0] MODE_DISABLED     = 3'd0;
  localparam logic [2:0] MODE_DISCONNECTED = 3'd1;
  localparam logic [2:0] MODE_IDLE         = 3'd2;
  localparam logic [2:0] MODE_FETCHING     = 3'd3;
  localparam logic [2:0] MODE_SUSPENDED    = 3'd4;

  // Event codes
  localparam logic [3:0] ACT_DATA_READY  = 4'd0;
  localparam logic [3:0] ACT_SAMPLE      = 4'd1;
  localparam logic [3:0] ACT_SUBSCRIBE   = 4'd2;
  localparam logic [3:0] ACT_UNSUBSCRIBE = 4'd3;
  localparam logic [3:0] ACT_POWER_DOWN  = 4'd4;
  localparam logic [3:0] ACT_WAKE        = 4'd5;
  localparam logic [3:0] ACT_USB_ACTIVE  = 4'd6;
  localparam logic [3:0] ACT_USB_SUSPEND = 4'd7;
  localparam logic [3:0] ACT_KEY         = 4'd8;
  localparam logic [3:0] ACT_START       = 4'd9;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CPI_ONE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CPI_TWO     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CPI_THREE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CPI_FOUR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_USB_RATE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RADIO_RATE  = 3'd6;

  localparam logic [7:0]  CPI_KEY      = 8'd5;
  localparam logic [7:0]  PEER_MAX     = 8'd255;
  localparam logic [15:0] DEFAULT_RATE = 16'd1000;

  typedef struct packed {
    logic [3:0]         action;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic [7:0]         key_code;
  } in_item_t;

  typedef struct packed {
    logic               report_valid;
    logic               report_to_usb;
    logic signed [15:0] report_dx;
    logic signed [15:0] report_dy;
    logic               flush_request;
    logic               polling_on;
    logic [15:0]        poll_rate_hz;
    logic               irq_enabled;
    logic [15:0]        cpi_value;
    logic               wake_request;
    logic [2:0]         mode_code;
  } out_item_t;

endpackage
`default_nettype wire

[design/motion_report_controller.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// motion_report_controller
// Mouse motion front-end controller: event decode, mode tracking, report
// routing and empty-sample flush.
// ----------------------------------------------------------------------------
// One event beat is taken per clock while in_stall is low; its result beat
// appears in the output register on the next clock. The whole event decode
// and state update is one stage between the input handshake and the output
// register, so the block sustains one beat per cycle as long as the result
// side keeps draining. Configuration writes take effect on the next event.
module motion_report_controller (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  mrc_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  wire                          out_stall,
  output mrc_pkg::out_item_t           out_data,
  input  wire                          cfg_we,
  input  wire [mrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [mrc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mrc_pkg::*;

  logic [LIMIT_W-1:0] empty_limit_r;
  logic [15:0]        cpi_one_r, cpi_two_r, cpi_three_r, cpi_four_r;
  logic [15:0]        usb_rate_r, radio_rate_r;

  logic [2:0]             mode_r, mode_nxt;
  logic [7:0]             peer_r, peer_nxt;
  logic                   usb_r, usb_nxt;
  logic [COUNT_WIDTH-1:0] empty_r, empty_nxt;
  logic [STAGE_W-1:0]     stage_r, stage_nxt;
  logic                   poll_r, poll_nxt;
  logic                   irq_r, irq_nxt;

  logic      out_valid_r;
  out_item_t out_data_r, out_data_nxt;

  logic              accept;
  logic [CMP_W-1:0]  limit;
  logic [15:0]       rate_raw;
  logic [1:0]        stage_sel;
  logic              zero_sample;

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (CMP_W'(empty_limit_r) < COUNT_MAX) begin
      limit = CMP_W'(empty_limit_r);
    end else begin
      limit = COUNT_MAX;
    end
  end

  assign zero_sample = (in_data.delta_x == 16'sd0) && (in_data.delta_y == 16'sd0);

  always_comb begin
    mode_nxt  = mode_r;
    peer_nxt  = peer_r;
    usb_nxt   = usb_r;
    empty_nxt = empty_r;
    stage_nxt = stage_r;
    poll_nxt  = poll_r;
    irq_nxt   = irq_r;

    out_data_nxt = '0;

    case (in_data.action)
      ACT_DATA_READY: begin
        if (mode_r == MODE_IDLE || mode_r == MODE_DISCONNECTED) begin
          irq_nxt  = 1'b0;
          mode_nxt = MODE_FETCHING;
          poll_nxt = 1'b1;
        end else if (mode_r == MODE_SUSPENDED) begin
          out_data_nxt.wake_request = 1'b1;
        end
      end
      ACT_SAMPLE: begin
        if (mode_r == MODE_FETCHING) begin
          if (zero_sample && CMP_W'(empty_r) >= limit) begin
            empty_nxt = '0;
            out_data_nxt.flush_request = 1'b1;
            poll_nxt = 1'b0;
            mode_nxt = MODE_IDLE;
            irq_nxt  = 1'b1;
          end else begin
            if (zero_sample) begin
              empty_nxt = empty_r + 1'b1;
            end else begin
              empty_nxt = '0;
            end
            out_data_nxt.report_valid  = 1'b1;
            out_data_nxt.report_to_usb = usb_r;
            out_data_nxt.report_dx     = in_data.delta_x;
            out_data_nxt.report_dy     = in_data.delta_y;
          end
        end
      end
      ACT_SUBSCRIBE, ACT_UNSUBSCRIBE: begin
        if (in_data.action == ACT_SUBSCRIBE) begin
          if (peer_r != PEER_MAX) peer_nxt = peer_r + 8'd1;
        end else begin
          if (peer_r != 8'd0) peer_nxt = peer_r - 8'd1;
        end
        if (peer_nxt != 8'd0) begin
          if (mode_r == MODE_DISCONNECTED) begin
            mode_nxt = MODE_IDLE;
            irq_nxt  = 1'b1;
          end
        end else begin
          irq_nxt  = 1'b0;
          poll_nxt = 1'b0;
          mode_nxt = MODE_DISCONNECTED;
        end
      end
      ACT_POWER_DOWN: begin
        poll_nxt = 1'b0;
        irq_nxt  = 1'b1;
        mode_nxt = MODE_SUSPENDED;
      end
      ACT_WAKE: begin
        if (mode_r == MODE_SUSPENDED) begin
          poll_nxt = 1'b1;
          mode_nxt = MODE_FETCHING;
        end
      end
      ACT_USB_ACTIVE: begin
        usb_nxt = 1'b1;
        if (mode_r == MODE_IDLE || mode_r == MODE_DISCONNECTED) begin
          irq_nxt  = 1'b0;
          mode_nxt = MODE_FETCHING;
          poll_nxt = 1'b1;
        end
      end
      ACT_USB_SUSPEND: begin
        usb_nxt = 1'b0;
      end
      ACT_KEY: begin
        if (in_data.key_code == CPI_KEY) begin
          if (stage_r == STAGE_W'(STAGE_COUNT - 1)) begin
            stage_nxt = '0;
          end else begin
            stage_nxt = stage_r + 1'b1;
          end
        end
      end
      ACT_START: begin
        if (mode_r == MODE_DISABLED) begin
          stage_nxt = STAGE_W'(1);
          mode_nxt  = (peer_r != 8'd0) ? MODE_IDLE : MODE_DISCONNECTED;
          irq_nxt   = 1'b1;
        end
      end
      default: begin
      end
    endcase

    rate_raw  = usb_nxt ? usb_rate_r : radio_rate_r;
    stage_sel = 2'(stage_nxt);

    out_data_nxt.polling_on   = poll_nxt;
    out_data_nxt.poll_rate_hz = (rate_raw == 16'd0) ? DEFAULT_RATE : rate_raw;
    out_data_nxt.irq_enabled  = irq_nxt;
    out_data_nxt.mode_code    = mode_nxt;
    case (stage_sel)
      2'd0:    out_data_nxt.cpi_value = cpi_one_r;
      2'd1:    out_data_nxt.cpi_value = cpi_two_r;
      2'd2:    out_data_nxt.cpi_value = cpi_three_r;
      default: out_data_nxt.cpi_value = cpi_four_r;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_limit_r <= LIMIT_W'(10);
      cpi_one_r     <= 16'd400;
      cpi_two_r     <= 16'd1600;
      cpi_three_r   <= 16'd3200;
      cpi_four_r    <= 16'd16000;
      usb_rate_r    <= 16'd1000;
      radio_rate_r  <= 16'd8000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EMPTY_LIMIT: empty_limit_r <= cfg_wdata[LIMIT_W-1:0];
        REG_CPI_ONE:     cpi_one_r     <= cfg_wdata;
        REG_CPI_TWO:     cpi_two_r     <= cfg_wdata;
        REG_CPI_THREE:   cpi_three_r   <= cfg_wdata;
        REG_CPI_FOUR:    cpi_four_r    <= cfg_wdata;
        REG_USB_RATE:    usb_rate_r    <= cfg_wdata;
        REG_RADIO_RATE:  radio_rate_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_DISABLED;
      peer_r  <= '0;
      usb_r   <= 1'b0;
      empty_r <= '0;
      stage_r <= STAGE_W'(1);
      poll_r  <= 1'b0;
      irq_r   <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      peer_r  <= peer_nxt;
      usb_r   <= usb_nxt;
      empty_r <= empty_nxt;
      stage_r <= stage_nxt;
      poll_r  <= poll_nxt;
      irq_r   <= irq_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of motion_report_controller. It drives event beats with random
// gaps against a result side with random stalls. Each accepted event runs
// through a local predictor of mode, peer count, link, empty-sample count and
// CPI stage. Every result beat is checked field by field against the oldest
// prediction. Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import mrc_pkg::*;

  localparam int         WATCHDOG_LIMIT  = 2000;
  localparam logic [3:0] ACT_SPARE_FIRST = 4'd10;
  localparam logic [3:0] ACT_SPARE_LAST  = 4'd15;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state and register copies
  logic [2:0]  ctl_mode;
  logic [7:0]  ctl_peers;
  logic        ctl_usb;
  int unsigned ctl_empty;
  int unsigned ctl_stage;
  logic        ctl_polling;
  logic        ctl_irq;
  logic [9:0]  ctl_limit;
  logic [15:0] ctl_cpi [4];
  logic [15:0] ctl_usb_rate;
  logic [15:0] ctl_radio_rate;

  out_item_t   pending_status [$];
  out_item_t   last_status;
  int          errors        = 0;
  int          beats_sent    = 0;
  int          beats_checked = 0;
  int          flush_seen    = 0;
  int          usb_reports   = 0;
  int          wake_seen     = 0;
  logic [7:0]  peak_peers    = '0;
  bit          idling        = 1'b1;
  int          stall_left    = 0;
  int          quiet         = 0;

  always #4 clk = ~clk;

  motion_report_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  function automatic void enter_fetching();
    ctl_irq     = 1'b0;
    ctl_mode    = MODE_FETCHING;
    ctl_polling = 1'b1;
  endfunction

  function automatic void peers_update();
    if (ctl_peers != 0) begin
      if (ctl_mode == MODE_DISCONNECTED) begin
        ctl_mode = MODE_IDLE;
        ctl_irq  = 1'b1;
      end
    end else begin
      ctl_irq     = 1'b0;
      ctl_polling = 1'b0;
      ctl_mode    = MODE_DISCONNECTED;
    end
  endfunction

  function automatic out_item_t step_controller(in_item_t ev);
    out_item_t   r;
    int unsigned cap;
    int unsigned lim;
    logic [15:0] rate;
    r   = '0;
    cap = (1 << COUNT_WIDTH) - 1;
    lim = (ctl_limit < cap) ? ctl_limit : cap;
    case (ev.action)
      ACT_DATA_READY: begin
        if (ctl_mode == MODE_IDLE || ctl_mode == MODE_DISCONNECTED) begin
          enter_fetching();
        end else if (ctl_mode == MODE_SUSPENDED) begin
          r.wake_request = 1'b1;
        end
      end
      ACT_SAMPLE: begin
        if (ctl_mode == MODE_FETCHING) begin
          r.report_valid = 1'b1;
          if (ev.delta_x == 0 && ev.delta_y == 0) begin
            if (ctl_empty < lim) begin
              ctl_empty = (ctl_empty + 1) & cap;
            end else begin
              ctl_empty       = 0;
              r.flush_request = 1'b1;
              r.report_valid  = 1'b0;
              ctl_polling     = 1'b0;
              ctl_mode        = MODE_IDLE;
              ctl_irq         = 1'b1;
            end
          end else begin
            ctl_empty = 0;
          end
          if (r.report_valid) begin
            r.report_to_usb = ctl_usb;
            r.report_dx     = ev.delta_x;
            r.report_dy     = ev.delta_y;
          end
        end
      end
      ACT_SUBSCRIBE: begin
        if (ctl_peers != PEER_MAX) ctl_peers++;
        peers_update();
      end
      ACT_UNSUBSCRIBE: begin
        if (ctl_peers != 0) ctl_peers--;
        peers_update();
      end
      ACT_POWER_DOWN: begin
        ctl_polling = 1'b0;
        ctl_irq     = 1'b1;
        ctl_mode    = MODE_SUSPENDED;
      end
      ACT_WAKE: begin
        if (ctl_mode == MODE_SUSPENDED) begin
          ctl_polling = 1'b1;
          ctl_mode    = MODE_FETCHING;
        end
      end
      ACT_USB_ACTIVE: begin
        ctl_usb = 1'b1;
        if (ctl_mode == MODE_IDLE || ctl_mode == MODE_DISCONNECTED) enter_fetching();
      end
      ACT_USB_SUSPEND: ctl_usb = 1'b0;
      ACT_KEY: begin
        if (ev.key_code == CPI_KEY) ctl_stage = (ctl_stage + 1) % STAGE_COUNT;
      end
      ACT_START: begin
        if (ctl_mode == MODE_DISABLED) begin
          ctl_stage = 1;
          ctl_mode  = (ctl_peers != 0) ? MODE_IDLE : MODE_DISCONNECTED;
          ctl_irq   = 1'b1;
        end
      end
      default: ;
    endcase
    rate           = ctl_usb ? ctl_usb_rate : ctl_radio_rate;
    r.poll_rate_hz = (rate == 0) ? DEFAULT_RATE : rate;
    r.polling_on   = ctl_polling;
    r.irq_enabled  = ctl_irq;
    r.cpi_value    = ctl_cpi[2'(ctl_stage)];
    r.mode_code    = ctl_mode;
    return r;
  endfunction

  function automatic in_item_t ev_of(logic [3:0] act, logic [15:0] dx, logic [15:0] dy,
                                     logic [7:0] key);
    in_item_t ev;
    ev.action   = act;
    ev.delta_x  = dx;
    ev.delta_y  = dy;
    ev.key_code = key;
    return ev;
  endfunction

  function automatic logic [15:0] pick_delta();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_event();
    in_item_t ev;
    int       pick;
    ev.delta_x  = 16'($urandom);
    ev.delta_y  = 16'($urandom);
    ev.key_code = 8'($urandom);
    pick        = $urandom_range(0, 99);
    if (pick < 14)      ev.action = ACT_DATA_READY;
    else if (pick < 50) ev.action = ACT_SAMPLE;
    else if (pick < 57) ev.action = ACT_SUBSCRIBE;
    else if (pick < 62) ev.action = ACT_UNSUBSCRIBE;
    else if (pick < 65) ev.action = ACT_POWER_DOWN;
    else if (pick < 70) ev.action = ACT_WAKE;
    else if (pick < 75) ev.action = ACT_USB_ACTIVE;
    else if (pick < 80) ev.action = ACT_USB_SUSPEND;
    else if (pick < 92) ev.action = ACT_KEY;
    else if (pick < 96) ev.action = ACT_START;
    else                ev.action = 4'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    if (ev.action == ACT_SAMPLE) begin
      ev.delta_x = pick_delta();
      ev.delta_y = pick_delta();
      if ($urandom_range(0, 2) == 0) begin
        ev.delta_x = '0;
        ev.delta_y = '0;
      end
    end
    if (ev.action == ACT_KEY && $urandom_range(0, 1) == 0) ev.key_code = CPI_KEY;
    return ev;
  endfunction

  // valid stays high after a beat is taken; the caller either sends the next
  // beat or drops valid in the same step
  task automatic push_beat(in_item_t ev);
    int gap;
    if (idling && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    last_status = step_controller(ev);
    pending_status.push_back(last_status);
    beats_sent++;
    if (last_status.flush_request) flush_seen++;
    if (last_status.report_valid && last_status.report_to_usb) usb_reports++;
    if (last_status.wake_request) wake_seen++;
    if (ctl_peers > peak_peers) peak_peers = ctl_peers;
  endtask

  task automatic settle_outputs();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_EMPTY_LIMIT: ctl_limit      = val[9:0];
      REG_CPI_ONE:     ctl_cpi[0]     = val;
      REG_CPI_TWO:     ctl_cpi[1]     = val;
      REG_CPI_THREE:   ctl_cpi[2]     = val;
      REG_CPI_FOUR:    ctl_cpi[3]     = val;
      REG_USB_RATE:    ctl_usb_rate   = val;
      REG_RADIO_RATE:  ctl_radio_rate = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [15:0] lim, logic [15:0] c0, logic [15:0] c1,
                              logic [15:0] c2, logic [15:0] c3, logic [15:0] ur,
                              logic [15:0] rr);
    write_reg(REG_EMPTY_LIMIT, lim);
    write_reg(REG_CPI_ONE, c0);
    write_reg(REG_CPI_TWO, c1);
    write_reg(REG_CPI_THREE, c2);
    write_reg(REG_CPI_FOUR, c3);
    write_reg(REG_USB_RATE, ur);
    write_reg(REG_RADIO_RATE, rr);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // reset register values; every event class and mode special case once
  task automatic test_directed_events();
    push_beat(ev_of(ACT_DATA_READY, 16'h0000, 16'h0000, 8'h00));
    push_beat(ev_of(ACT_SAMPLE, 16'h7FFF, 16'h8000, 8'h00));
    push_beat(ev_of(ACT_WAKE, 16'h0000, 16'h0000, 8'h00));
    push_beat(ev_of(ACT_SPARE_LAST, 16'hFFFF, 16'hFFFF, 8'hFF));
    push_beat(ev_of(ACT_KEY, 16'h0000, 16'h0000, CPI_KEY));
    push_beat(ev_of(ACT_SUBSCRIBE, 16'h0000, 16'h0000, 8'h00));
    push_beat(ev_of(ACT_START, 16'h0000, 16'h0000, 8'h00));
    push_beat(ev_of(ACT_START, 16'h0000, 16'h0000, 8'h00));
    push_beat(ev_of(ACT_DATA_READY, 16'h0000, 16'h0000, 8'h00));
    push_beat(ev_of(ACT_SAMPLE, 16'h7FFF, 16'h8000, 8'h00));
    push_beat(ev_of(ACT_SAMPLE, 16'h8000, 16'h7FFF, 8'h00));
    push_beat(ev_of(ACT_SAMPLE, 16'h0000, 16'h0000, 8'h00));
    push_beat(ev_of(ACT_DATA_READY, 16'h0000, 16'h0000, 8'h00));
    push_beat(ev_of(ACT_USB_ACTIVE, 16'h0000, 16'h0000, 8'h00));
    push_beat(ev_of(ACT_SAMPLE, 16'hFFFF, 16'h0001, 8'h00));
    push_beat(ev_of(ACT_USB_SUSPEND, 16'h0000, 16'h0000, 8'h00));
    push_beat(ev_of(ACT_POWER_DOWN, 16'h0000, 16'h0000, 8'h00));
    push_beat(ev_of(ACT_DATA_READY, 16'h0000, 16'h0000, 8'h00));
    push_beat(ev_of(ACT_WAKE, 16'h0000, 16'h0000, 8'h00));
    push_beat(ev_of(ACT_KEY, 16'h0000, 16'h0000, 8'hFF));
    push_beat(ev_of(ACT_UNSUBSCRIBE, 16'h0000, 16'h0000, 8'h00));
    push_beat(ev_of(ACT_UNSUBSCRIBE, 16'h0000, 16'h0000, 8'h00));
    push_beat(ev_of(ACT_USB_ACTIVE, 16'h0000, 16'h0000, 8'h00));
    push_beat(ev_of(ACT_SPARE_FIRST, 16'h0000, 16'h0000, 8'h00));
    settle_outputs();
  endtask

  // limit zero flushes on the first empty sample; limit write has upper bits set
  task automatic test_empty_flush();
    program_regs(16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h0000, 16'hFFFF);
    push_beat(ev_of(ACT_SAMPLE, 16'h0000, 16'h0000, 8'h00));
    push_beat(ev_of(ACT_DATA_READY, 16'h0000, 16'h0000, 8'h00));
    push_beat(ev_of(ACT_USB_SUSPEND, 16'h0000, 16'h0000, 8'h00));
    push_beat(ev_of(ACT_SAMPLE, 16'h0000, 16'h0000, 8'h00));
    settle_outputs();
    program_regs(16'hFC03, 16'd400, 16'd1600, 16'd3200, 16'd16000, 16'd1000, 16'h0000);
    push_beat(ev_of(ACT_DATA_READY, 16'h0000, 16'h0000, 8'h00));
    repeat (4) push_beat(ev_of(ACT_SAMPLE, 16'h0000, 16'h0000, 8'h00));
    settle_outputs();
  endtask

  // subscribe up to saturation, then unsubscribe down to zero, mixed with noise
  task automatic test_peer_sweep();
    in_item_t ev;
    while (ctl_peers != PEER_MAX) begin
      ev = random_event();
      if (ev.action == ACT_UNSUBSCRIBE || $urandom_range(0, 4) != 0) ev.action = ACT_SUBSCRIBE;
      push_beat(ev);
    end
    repeat (8) push_beat(ev_of(ACT_SUBSCRIBE, 16'($urandom), 16'($urandom), 8'($urandom)));
    while (ctl_peers != 0) begin
      ev = random_event();
      if (ev.action == ACT_SUBSCRIBE || $urandom_range(0, 4) != 0) ev.action = ACT_UNSUBSCRIBE;
      push_beat(ev);
    end
    repeat (8) push_beat(ev_of(ACT_UNSUBSCRIBE, 16'($urandom), 16'($urandom), 8'($urandom)));
    settle_outputs();
  endtask

  // long limit with upper bits set: a long run of empty samples before the flush
  task automatic test_long_zero_run();
    in_item_t ev;
    program_regs(16'hFC96, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom));
    push_beat(ev_of(ACT_SUBSCRIBE, 16'h0000, 16'h0000, 8'h00));
    push_beat(ev_of(ACT_WAKE, 16'h0000, 16'h0000, 8'h00));
    push_beat(ev_of(ACT_DATA_READY, 16'h0000, 16'h0000, 8'h00));
    push_beat(ev_of(ACT_SAMPLE, 16'h1234, 16'hEDCB, 8'h00));
    do begin
      ev = ev_of(ACT_SAMPLE, 16'h0000, 16'h0000, 8'($urandom));
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 4))
          0:       ev.action = ACT_USB_ACTIVE;
          1:       ev.action = ACT_USB_SUSPEND;
          2:       ev.action = ACT_DATA_READY;
          3:       ev.action = ACT_SUBSCRIBE;
          default: ev.action = ACT_KEY;
        endcase
        ev.delta_x = 16'($urandom);
        ev.delta_y = 16'($urandom);
      end
      push_beat(ev);
    end while (!last_status.flush_request);
    settle_outputs();
  endtask

  task automatic test_random_phases();
    logic [15:0] lim;
    for (int phase = 0; phase < 6; phase++) begin
      lim = 16'(($urandom & 32'h0000FC00) | $urandom_range(0, 4));
      case (phase)
        0: program_regs(lim, 16'd400, 16'd1600, 16'd3200, 16'd16000, 16'd1000, 16'd8000);
        1: program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                        16'h0000);
        2: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF);
        default: program_regs(lim, 16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      if (phase == 5) idling = 1'b0;
      repeat (40) push_beat(random_event());
      settle_outputs();
      repeat (40) push_beat(random_event());
      settle_outputs();
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_status.size() == 0) begin
        $error("result beat with no event pending");
        errors++;
      end else begin
        want = pending_status.pop_front();
        compare_field("report_valid", 16'(want.report_valid), 16'(out_data.report_valid));
        compare_field("report_to_usb", 16'(want.report_to_usb),
                      16'(out_data.report_to_usb));
        compare_field("report_dx", want.report_dx, out_data.report_dx);
        compare_field("report_dy", want.report_dy, out_data.report_dy);
        compare_field("flush_request", 16'(want.flush_request),
                      16'(out_data.flush_request));
        compare_field("polling_on", 16'(want.polling_on), 16'(out_data.polling_on));
        compare_field("poll_rate_hz", want.poll_rate_hz, out_data.poll_rate_hz);
        compare_field("irq_enabled", 16'(want.irq_enabled), 16'(out_data.irq_enabled));
        compare_field("cpi_value", want.cpi_value, out_data.cpi_value);
        compare_field("wake_request", 16'(want.wake_request), 16'(out_data.wake_request));
        compare_field("mode_code", 16'(want.mode_code), 16'(out_data.mode_code));
        beats_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    ctl_mode       = MODE_DISABLED;
    ctl_peers      = '0;
    ctl_usb        = 1'b0;
    ctl_empty      = 0;
    ctl_stage      = 1;
    ctl_polling    = 1'b0;
    ctl_irq        = 1'b0;
    ctl_limit      = 10'd10;
    ctl_cpi[0]     = 16'd400;
    ctl_cpi[1]     = 16'd1600;
    ctl_cpi[2]     = 16'd3200;
    ctl_cpi[3]     = 16'd16000;
    ctl_usb_rate   = 16'd1000;
    ctl_radio_rate = 16'd8000;
    last_status    = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_events();
    test_empty_flush();
    test_peer_sweep();
    test_long_zero_run();
    test_random_phases();
    repeat (8) @(posedge clk);
    $display("covered %0d events, %0d result beats: %0d flushes, %0d usb reports, %0d wakes",
             beats_sent, beats_checked, flush_seen, usb_reports, wake_seen);
    $display("peer count peaked at %0d; registers swept through zero, max and random values",
             peak_peers);
    if (errors == 0 && pending_status.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
